@@ design/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and constants of the thermostat setpoint controller.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int MAX_DIGITS = 2;

	localparam logic [7:0] KEY_STAR = 8'd42;
	localparam logic [7:0] KEY_HASH = 8'd35;
	localparam logic [7:0] KEY_ZERO = 8'd48;
	localparam logic [7:0] KEY_NINE = 8'd57;

	localparam logic [6:0] THRESH_RESET   = 7'd30;
	localparam logic [6:0] THRESH_MAX     = 7'd99;
	localparam logic [7:0] SHUTDOWN_RESET = 8'd60;

	// hundredths = floor(nibble * 625 / 100) mod 100 = floor(nibble * 25 / 4)
	localparam logic [8:0] HUND_SCALE = 9'd25;

	typedef enum logic [1:0] {
		OP_KEY     = 2'd0,
		OP_READING = 2'd1,
		OP_RESTORE = 2'd2
	} op_t;

	typedef enum logic {
		CFG_DEFAULT_THRESHOLD = 1'b0,
		CFG_SHUTDOWN_TEMP     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0] default_thresh;  // already saturated to 99
		logic [7:0] shutdown_temp;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key_code;
		logic [7:0] sensor_high;
		logic [7:0] sensor_low;
		logic [7:0] stored_byte;
	} item_t;

	typedef struct packed {
		logic       setup;
		logic [1:0] digit_count;
		logic       fan;
		logic       online;
		logic [6:0] threshold;
		logic [7:0] whole;
		logic [6:0] hund;
	} ctrl_state_t;

endpackage

@@ design/tsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tsc_cfg_regs
// Configuration registers: default threshold and server shutdown limit.
// ----------------------------------------------------------------------------
module tsc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [7:0]         wr_data,
	output tsc_pkg::cfg_t      cfg
);

	logic [6:0] default_q;
	logic [7:0] shutdown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q  <= tsc_pkg::THRESH_RESET;
			shutdown_q <= tsc_pkg::SHUTDOWN_RESET;
		end else if (wr_en) begin
			case (tsc_pkg::cfg_idx_t'(wr_index))
				tsc_pkg::CFG_DEFAULT_THRESHOLD: default_q  <= wr_data[6:0];
				tsc_pkg::CFG_SHUTDOWN_TEMP:     shutdown_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.default_thresh = (default_q > tsc_pkg::THRESH_MAX) ? tsc_pkg::THRESH_MAX
		                                                       : default_q;
		cfg.shutdown_temp  = shutdown_q;
	end

endmodule

@@ design/tsc_step.sv @@
// ----------------------------------------------------------------------------
// tsc_step
// Next-state logic for one item: key handling, reading scale, restore.
// ----------------------------------------------------------------------------
module tsc_step (
	input  tsc_pkg::item_t                    item,
	input  tsc_pkg::ctrl_state_t              cur,
	input  logic [3:0]                        digits [tsc_pkg::MAX_DIGITS],
	input  tsc_pkg::cfg_t                     cfg,
	output tsc_pkg::ctrl_state_t              nxt,
	output logic                              save,
	output logic [tsc_pkg::MAX_DIGITS-1:0]    digit_we,
	output logic [3:0]                        digit_val
);

	logic [8:0] hund_prod;
	logic [6:0] commit_val;
	logic [7:0] key;

	assign key       = item.key_code;
	assign digit_val = 4'(key - tsc_pkg::KEY_ZERO);
	assign hund_prod = {5'd0, item.sensor_low[7:4]} * tsc_pkg::HUND_SCALE;

	// value of the buffered digits, most significant first
	always_comb begin
		commit_val = '0;
		for (int i = 0; i < tsc_pkg::MAX_DIGITS; i++) begin
			if (2'(i) < cur.digit_count)
				commit_val = 7'(commit_val * 7'd10 + {3'd0, digits[i]});
		end
	end

	always_comb begin
		nxt      = cur;
		save     = 1'b0;
		digit_we = '0;
		case (tsc_pkg::op_t'(item.op))
			tsc_pkg::OP_KEY: begin
				if (!cur.setup) begin
					if (key == tsc_pkg::KEY_STAR) begin
						nxt.setup       = 1'b1;
						nxt.digit_count = '0;
						nxt.fan         = 1'b0;
					end
				end else if (key inside {[tsc_pkg::KEY_ZERO:tsc_pkg::KEY_NINE]}) begin
					if (cur.digit_count < 2'(tsc_pkg::MAX_DIGITS)) begin
						for (int i = 0; i < tsc_pkg::MAX_DIGITS; i++)
							digit_we[i] = (cur.digit_count == 2'(i));
						nxt.digit_count = cur.digit_count + 2'd1;
					end
				end else if (key == tsc_pkg::KEY_HASH) begin
					if (cur.digit_count != 2'd0) begin
						nxt.threshold = commit_val;
						save          = 1'b1;
					end
					nxt.setup       = 1'b0;
					nxt.digit_count = '0;
				end else if (key == tsc_pkg::KEY_STAR) begin
					nxt.setup       = 1'b0;
					nxt.digit_count = '0;
				end
			end
			tsc_pkg::OP_READING: begin
				if (!cur.setup) begin
					nxt.whole  = item.sensor_high;
					nxt.hund   = hund_prod[8:2];
					nxt.online = (item.sensor_high < cfg.shutdown_temp);
					nxt.fan    = (item.sensor_high >= {1'b0, cur.threshold});
				end
			end
			tsc_pkg::OP_RESTORE: begin
				if (item.stored_byte >= 8'd1 && item.stored_byte <= {1'b0, tsc_pkg::THRESH_MAX}) begin
					nxt.threshold = item.stored_byte[6:0];
				end else begin
					nxt.threshold = cfg.default_thresh;
					save          = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/thermostat_setpoint_controller_top.sv @@
// ----------------------------------------------------------------------------
// thermostat_setpoint_controller_top
// Fan thermostat with keypad setpoint entry, one result per input item.
// ----------------------------------------------------------------------------
// Takes one item per clock while out_ready does not stall. An accepted item is
// registered in the input register, its state update and result are computed
// in one pass of logic, and the result is registered in the result register.
// The only stall comes from out_ready: the input register takes items while
// it is empty or the result register is free or being emptied. cfg_ready is
// always high; write configuration only while no item is in flight.
module thermostat_setpoint_controller_top (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] key_code,
	input  logic [7:0] sensor_high,
	input  logic [7:0] sensor_low,
	input  logic [7:0] stored_byte,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       fan_on,
	output logic       server_online,
	output logic       in_setup,
	output logic [6:0] threshold_now,
	output logic [1:0] digits_entered,
	output logic       save_request,
	output logic [7:0] temp_whole,
	output logic [6:0] temp_hundredths,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	tsc_pkg::cfg_t        cfg;
	tsc_pkg::item_t       item_s1;
	logic                 valid_s1;
	tsc_pkg::ctrl_state_t st_q;
	tsc_pkg::ctrl_state_t st_nxt;
	logic [3:0]           digit_q [tsc_pkg::MAX_DIGITS];
	logic [tsc_pkg::MAX_DIGITS-1:0] digit_we;
	logic [3:0]           digit_val;
	logic                 save_nxt;
	logic                 save_q;
	logic                 out_valid_q;
	logic                 adv;
	logic                 in_fire;

	assign cfg_ready = 1'b1;

	tsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// result slot frees up when empty or when its transfer happens now
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.op          <= op;
			item_s1.key_code    <= key_code;
			item_s1.sensor_high <= sensor_high;
			item_s1.sensor_low  <= sensor_low;
			item_s1.stored_byte <= stored_byte;
		end
	end

	tsc_step u_step (
		.item      (item_s1),
		.cur       (st_q),
		.digits    (digit_q),
		.cfg       (cfg),
		.nxt       (st_nxt),
		.save      (save_nxt),
		.digit_we  (digit_we),
		.digit_val (digit_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.setup       <= 1'b0;
			st_q.digit_count <= '0;
			st_q.fan         <= 1'b0;
			st_q.online      <= 1'b1;
			st_q.threshold   <= tsc_pkg::THRESH_RESET;
			st_q.whole       <= '0;
			st_q.hund        <= '0;
			out_valid_q      <= 1'b0;
			save_q           <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q   <= st_nxt;
				save_q <= save_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < tsc_pkg::MAX_DIGITS; i++) begin
			if (adv && valid_s1 && digit_we[i])
				digit_q[i] <= digit_val;
		end
	end

	// the state registers hold the state after the item in the result slot
	assign out_valid       = out_valid_q;
	assign fan_on          = st_q.fan;
	assign server_online   = st_q.online;
	assign in_setup        = st_q.setup;
	assign threshold_now   = st_q.threshold;
	assign digits_entered  = st_q.digit_count;
	assign save_request    = save_q;
	assign temp_whole      = st_q.whole;
	assign temp_hundredths = st_q.hund;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.digit_count <= 2'(tsc_pkg::MAX_DIGITS))
		else $error("digit count beyond limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.setup |-> st_q.digit_count == 2'd0)
		else $error("digits buffered outside setup");

	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.setup |-> !st_q.fan)
		else $error("fan on during setup");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result slot");
`endif

endmodule

@@ tb/tb_thermostat_setpoint_controller_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermostat_setpoint_controller_top
// Directed and random checks of the thermostat setpoint controller.
// ----------------------------------------------------------------------------
// Keys, sensor readings and threshold restores go in over the item channel.
// Every accepted item yields one status result. A local model of the controller
// tracks setup mode, the digit buffer, threshold and last reading, and queues
// the status it expects. Results are checked in order as they come out, under
// random source gaps and sink stalls, across several register settings.
module tb_thermostat_setpoint_controller_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic       fan;
		logic       online;
		logic       setup;
		logic [6:0] thresh;
		logic [1:0] digits;
		logic       save;
		logic [7:0] whole;
		logic [6:0] hund;
	} status_t;

	bit clk = 1'b0;
	logic arst_n;

	logic       in_valid;
	logic       in_ready;
	logic [1:0] op;
	logic [7:0] key_code;
	logic [7:0] sensor_high;
	logic [7:0] sensor_low;
	logic [7:0] stored_byte;

	logic       out_valid;
	logic       out_ready;
	logic       fan_on;
	logic       server_online;
	logic       in_setup;
	logic [6:0] threshold_now;
	logic [1:0] digits_entered;
	logic       save_request;
	logic [7:0] temp_whole;
	logic [6:0] temp_hundredths;

	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	// controller model state
	logic       st_setup = 1'b0;
	int         st_digits = 0;
	logic [3:0] st_store [2];
	logic [6:0] st_thresh = tsc_pkg::THRESH_RESET;
	logic       st_fan = 1'b0;
	logic       st_online = 1'b1;
	logic [7:0] st_whole = 8'd0;
	logic [6:0] st_hund = 7'd0;
	logic [6:0] reg_default = tsc_pkg::THRESH_RESET;
	logic [7:0] reg_shutdown = tsc_pkg::SHUTDOWN_RESET;

	status_t pending_status [$];
	status_t seen_status;
	status_t want_status;

	int  mismatches = 0;
	int  items_sent = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	int  idle_pct = 0;
	bit  idle_on = 1'b1;

	thermostat_setpoint_controller_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.key_code        (key_code),
		.sensor_high     (sensor_high),
		.sensor_low      (sensor_low),
		.stored_byte     (stored_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fan_on          (fan_on),
		.server_online   (server_online),
		.in_setup        (in_setup),
		.threshold_now   (threshold_now),
		.digits_entered  (digits_entered),
		.save_request    (save_request),
		.temp_whole      (temp_whole),
		.temp_hundredths (temp_hundredths),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #6 clk = ~clk;

	// Apply one item to the controller model and queue the status it leaves.
	task automatic predict_status(input logic [1:0] o, input logic [7:0] k,
			input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] sb);
		int raw;
		int scaled;
		int val;
		logic save;
		status_t s;
		save = 1'b0;
		case (o)
			tsc_pkg::OP_KEY: begin
				if (!st_setup) begin
					if (k == tsc_pkg::KEY_STAR) begin
						st_setup = 1'b1;
						st_digits = 0;
						st_fan = 1'b0;
					end
				end else if (k >= tsc_pkg::KEY_ZERO && k <= tsc_pkg::KEY_NINE) begin
					if (st_digits < tsc_pkg::MAX_DIGITS) begin
						st_store[st_digits] = 4'(k - tsc_pkg::KEY_ZERO);
						st_digits++;
					end
				end else if (k == tsc_pkg::KEY_HASH) begin
					if (st_digits > 0) begin
						val = 0;
						for (int i = 0; i < st_digits; i++)
							val = val * 10 + int'(st_store[i]);
						st_thresh = val[6:0];
						save = 1'b1;
					end
					st_setup = 1'b0;
					st_digits = 0;
				end else if (k == tsc_pkg::KEY_STAR) begin
					st_setup = 1'b0;
					st_digits = 0;
				end
			end
			tsc_pkg::OP_READING: begin
				if (!st_setup) begin
					raw = int'({hi, lo[7:4]});
					scaled = raw * 625 / 100;
					st_whole = 8'(scaled / 100);
					st_hund = 7'(scaled % 100);
					st_online = st_whole < reg_shutdown;
					st_fan = st_whole >= {1'b0, st_thresh};
				end
			end
			tsc_pkg::OP_RESTORE: begin
				if (sb >= 8'd1 && sb <= {1'b0, tsc_pkg::THRESH_MAX}) begin
					st_thresh = sb[6:0];
				end else begin
					st_thresh = (reg_default > tsc_pkg::THRESH_MAX) ? tsc_pkg::THRESH_MAX
					                                                : reg_default;
					save = 1'b1;
				end
			end
			default: ;
		endcase
		s.fan = st_fan;
		s.online = st_online;
		s.setup = st_setup;
		s.thresh = st_thresh;
		s.digits = st_digits[1:0];
		s.save = save;
		s.whole = st_whole;
		s.hund = st_hund;
		pending_status.push_back(s);
	endtask

	task automatic send_item(input logic [1:0] o, input logic [7:0] k,
			input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] sb);
		if (idle_on && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		key_code <= k;
		sensor_high <= hi;
		sensor_low <= lo;
		stored_byte <= sb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		predict_status(o, k, hi, lo, sb);
	endtask

	// unused fields carry random values; the controller must ignore them
	task automatic send_key(input logic [7:0] k);
		send_item(tsc_pkg::OP_KEY, k, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_reading(input logic [7:0] hi, input logic [7:0] lo);
		send_item(tsc_pkg::OP_READING, 8'($urandom_range(0, 255)), hi, lo,
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_restore(input logic [7:0] sb);
		send_item(tsc_pkg::OP_RESTORE, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sb);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input tsc_pkg::cfg_idx_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == tsc_pkg::CFG_DEFAULT_THRESHOLD)
			reg_default = data[6:0];
		else
			reg_shutdown = data;
	endtask

	task automatic configure(input logic [7:0] dflt, input logic [7:0] shut);
		wait_idle();
		write_register(tsc_pkg::CFG_DEFAULT_THRESHOLD, dflt);
		write_register(tsc_pkg::CFG_SHUTDOWN_TEMP, shut);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_keys_outside_setup();
		send_key(8'd0);
		send_key(tsc_pkg::KEY_HASH);
		send_key(tsc_pkg::KEY_ZERO + 8'd5);
		send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
	endtask

	task automatic test_setpoint_entry();
		send_key(tsc_pkg::KEY_STAR);
		send_key(tsc_pkg::KEY_NINE);
		send_key(tsc_pkg::KEY_NINE);
		send_key(tsc_pkg::KEY_ZERO + 8'd7);  // third digit, dropped
		send_key(8'h41);                     // not a digit
		send_reading(8'd120, 8'hF0);         // ignored in setup
		send_restore(8'd55);                 // applies, setup stays
		send_key(tsc_pkg::KEY_HASH);         // commits 99
		send_key(tsc_pkg::KEY_STAR);
		send_key(tsc_pkg::KEY_HASH);         // exit, nothing saved
		send_key(tsc_pkg::KEY_STAR);
		send_key(tsc_pkg::KEY_ZERO);
		send_key(tsc_pkg::KEY_ZERO);
		send_key(tsc_pkg::KEY_HASH);         // threshold 0
		send_reading(8'd0, 8'd0);
		send_key(tsc_pkg::KEY_STAR);
		send_key(tsc_pkg::KEY_ZERO + 8'd4);
		send_key(tsc_pkg::KEY_STAR);         // cancel
		send_key(tsc_pkg::KEY_STAR);
		send_key(tsc_pkg::KEY_ZERO + 8'd5);
		send_key(tsc_pkg::KEY_HASH);         // single digit
	endtask

	task automatic test_reading_extremes();
		send_reading(8'd0, 8'hFF);
		send_reading(8'd255, 8'hF0);
		send_reading(8'd255, 8'h0F);
		send_reading(8'd59, 8'hFF);
		send_reading(8'd60, 8'h00);
		send_reading(8'd4, 8'h80);
	endtask

	task automatic test_restore_range();
		send_restore(8'd0);
		send_restore(8'd1);
		send_restore(8'd99);
		send_restore(8'd100);
		send_restore(8'd255);
	endtask

	task automatic test_register_extremes();
		configure(8'd0, 8'd0);
		send_restore(8'd0);         // default of zero used as is
		send_reading(8'd0, 8'd0);
		configure(8'hFF, 8'd255);
		send_restore(8'd200);       // default saturates to 99
		send_reading(8'd255, 8'hFF);
		send_reading(8'd98, 8'h00);
		configure(8'd99, 8'd1);
		send_restore(8'd128);
		send_reading(8'd1, 8'h10);
	endtask

	task automatic setpoint_sequence();
		int ndig;
		int ending;
		if (!st_setup)
			send_key(tsc_pkg::KEY_STAR);
		ndig = $urandom_range(0, 3);
		for (int i = 0; i < ndig; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_key(8'($urandom_range(0, 255)));
			send_key(tsc_pkg::KEY_ZERO + 8'($urandom_range(0, 9)));
		end
		ending = $urandom_range(0, 99);
		if (ending < 70)
			send_key(tsc_pkg::KEY_HASH);
		else if (ending < 90)
			send_key(tsc_pkg::KEY_STAR);
	endtask

	task automatic random_mix(input int count);
		int stop_at;
		int pick;
		int near;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				setpoint_sequence();
			end else if (pick < 65) begin
				case ($urandom_range(0, 2))
					0: near = int'(st_thresh);
					1: near = int'(reg_shutdown);
					default: near = $urandom_range(0, 255);
				endcase
				near = near + $urandom_range(0, 4) - 2;
				send_reading(near[7:0], 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				if ($urandom_range(0, 1))
					send_restore(8'($urandom_range(1, 99)));
				else
					send_restore(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				send_key(8'($urandom_range(0, 255)));
			end else begin
				send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_random_traffic(input int count);
		configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		idle_pct = $urandom_range(0, 40);
		random_mix(count);
	endtask

	task automatic test_steady_stream(input int count);
		idle_on <= 1'b0;
		configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_mix(count);
	endtask

	// sink side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (!idle_on || !arst_n) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_status = {fan_on, server_online, in_setup, threshold_now,
				digits_entered, save_request, temp_whole, temp_hundredths};
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result transfer with nothing outstanding", $realtime);
			end else begin
				want_status = pending_status.pop_front();
				if (seen_status !== want_status) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: status mismatch", $realtime);
						$display("  exp fan=%b onl=%b set=%b thr=%0d dig=%0d sav=%b t=%0d.%02d",
							want_status.fan, want_status.online, want_status.setup,
							want_status.thresh, want_status.digits, want_status.save,
							want_status.whole, want_status.hund);
						$display("  got fan=%b onl=%b set=%b thr=%0d dig=%0d sav=%b t=%0d.%02d",
							seen_status.fan, seen_status.online, seen_status.setup,
							seen_status.thresh, seen_status.digits, seen_status.save,
							seen_status.whole, seen_status.hund);
					end
				end
			end
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		op <= tsc_pkg::OP_KEY;
		key_code <= 8'd0;
		sensor_high <= 8'd0;
		sensor_low <= 8'd0;
		stored_byte <= 8'd0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= tsc_pkg::CFG_DEFAULT_THRESHOLD;
		cfg_data <= 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_keys_outside_setup();
		test_setpoint_entry();
		test_reading_extremes();
		test_restore_range();
		test_register_extremes();
		repeat (4) test_random_traffic(350);
		test_steady_stream(200);

		wait_idle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ thermostat_setpoint_controller_top.f @@
design/tsc_pkg.sv
design/tsc_cfg_regs.sv
design/tsc_step.sv
design/thermostat_setpoint_controller_top.sv
tb/tb_thermostat_setpoint_controller_top.sv
